// ----- design/ffrf_pkg.sv -----
// Shared types and constants for the FAT32 free cluster run finder.
// Used by the scan core, the sector stage, the top level and the checker.
package ffrf_pkg;

  localparam int CLUSTER_BITS_DEF = 28;
  localparam int RUN_W            = 28;   // width of run_start / run_length fields
  localparam int ENTRY_W          = 32;
  localparam int SECTOR_W         = 32;
  localparam int OUT_DATA_W       = 120;  // four fields, 120 bits, already whole bytes
  localparam int OUT_USER_W       = 2;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 32;
  localparam int FIRST_CLUSTER    = 2;
  localparam int ENTRY_CLU_BITS   = 28;   // low bits of an entry that mark it in use

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_BYTES     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_SECTORS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_START_SECTOR = 2'd2;

  localparam logic [31:0] REQUEST_BYTES_RST     = 32'd0;
  localparam logic [7:0]  CLUSTER_SECTORS_RST   = 8'd8;
  localparam logic [31:0] DATA_START_SECTOR_RST = 32'd0;

  typedef struct packed {
    logic [31:0] request_bytes;
    logic [7:0]  cluster_sectors;
    logic [31:0] data_start_sector;
  } cfg_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_start;
    logic [RUN_W-1:0] run_length;
    logic             found;
    logic             size_met;
  } run_result_t;

endpackage

// ----- design/ffrf_scan.sv -----
// Scan core: run tracking state, size test and the run result register.
// Depends on ffrf_pkg.
module ffrf_scan
  import ffrf_pkg::*;
#(
  parameter int CLUSTER_BITS = CLUSTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  input  logic [ENTRY_W-1:0]  in_entry,
  input  logic                in_last,
  output logic                in_ready,
  output logic                res_valid,
  output run_result_t         res,
  input  logic                res_ready
);

  localparam int W  = CLUSTER_BITS;
  localparam int PW = CLUSTER_BITS + 8;
  localparam logic [W-1:0] CLU_MAX   = '1;
  localparam logic [W-1:0] CLU_FIRST = W'(FIRST_CLUSTER);

  logic [W-1:0] cluster_index, cluster_index_next;
  logic [W-1:0] current_start, current_start_next;
  logic [W-1:0] current_length, current_length_next;
  logic [W-1:0] best_start, best_start_next;
  logic [W-1:0] best_length, best_length_next;
  logic         search_done, search_done_next;

  logic         consume;
  logic         emit;
  logic         met;
  logic         entry_free;
  logic [PW-1:0] size_units;
  logic [23:0]  req_units;
  logic [W-1:0] fin_start;
  logic [W-1:0] fin_length;
  run_result_t  res_next;

  assign in_ready = !res_valid || res_ready;
  assign consume  = in_valid && in_ready;

  // request in 512-byte units, rounded up, so the size test needs no shift
  assign req_units  = {1'b0, cfg.request_bytes[31:9]} + 24'(|cfg.request_bytes[8:0]);
  assign entry_free = (in_entry[ENTRY_CLU_BITS-1:0] == '0);

  always_comb begin
    cluster_index_next  = cluster_index;
    current_start_next  = current_start;
    current_length_next = current_length;
    best_start_next     = best_start;
    best_length_next    = best_length;
    search_done_next    = search_done;
    met                 = 1'b0;
    emit                = 1'b0;
    size_units          = '0;
    fin_start           = '0;
    fin_length          = '0;
    res_next            = '0;

    if (search_done) begin
      if (in_last) begin
        cluster_index_next  = CLU_FIRST;
        current_start_next  = '0;
        current_length_next = '0;
        best_start_next     = '0;
        best_length_next    = '0;
        search_done_next    = 1'b0;
      end
    end else begin
      if (entry_free) begin
        if (current_length == '0) begin
          current_start_next  = cluster_index;
          current_length_next = W'(1);
        end else begin
          if (current_length != CLU_MAX) begin
            current_length_next = current_length + W'(1);
          end
          size_units = PW'(current_length_next) * PW'(cfg.cluster_sectors);
          met = (cfg.request_bytes != '0) && (size_units >= PW'(req_units));
        end
      end else if (current_length != '0) begin
        if (current_length > best_length) begin
          best_start_next  = current_start;
          best_length_next = current_length;
        end
        current_start_next  = '0;
        current_length_next = '0;
      end

      if (!met) begin
        cluster_index_next = cluster_index + W'(1);
      end

      emit       = met || in_last;
      fin_start  = best_start_next;
      fin_length = best_length_next;
      if (current_length_next != '0 && current_length_next > best_length_next) begin
        fin_start  = current_start_next;
        fin_length = current_length_next;
      end

      res_next.found      = (fin_length != '0);
      res_next.run_start  = res_next.found ? RUN_W'(fin_start) : '0;
      res_next.run_length = RUN_W'(fin_length);
      res_next.size_met   = met;

      if (in_last) begin
        cluster_index_next  = CLU_FIRST;
        current_start_next  = '0;
        current_length_next = '0;
        best_start_next     = '0;
        best_length_next    = '0;
        search_done_next    = 1'b0;
      end else if (met) begin
        // hold the state; everything up to the last entry is dropped
        best_start_next  = fin_start;
        best_length_next = fin_length;
        search_done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_index  <= CLU_FIRST;
      current_start  <= '0;
      current_length <= '0;
      best_start     <= '0;
      best_length    <= '0;
      search_done    <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (consume) begin
        cluster_index  <= cluster_index_next;
        current_start  <= current_start_next;
        current_length <= current_length_next;
        best_start     <= best_start_next;
        best_length    <= best_length_next;
        search_done    <= search_done_next;
      end
      if (in_ready) begin
        res_valid <= consume && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      res <= res_next;
    end
  end

endmodule

// ----- design/ffrf_sector.sv -----
// Sector stage: turns the chosen run into absolute sectors, holds the output register.
// Depends on ffrf_pkg.
module ffrf_sector
  import ffrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  res_valid,
  input  run_result_t           res,
  output logic                  res_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [OUT_USER_W-1:0] out_user
);

  logic [SECTOR_W-1:0] start_rel;
  logic [SECTOR_W-1:0] end_rel;
  logic [SECTOR_W-1:0] first_sector;
  logic [SECTOR_W-1:0] last_sector;
  logic [SECTOR_W-1:0] cs_ext;

  assign res_ready = !out_valid || out_ready;
  assign cs_ext    = SECTOR_W'(cfg.cluster_sectors);

  always_comb begin
    start_rel = SECTOR_W'(res.run_start) - SECTOR_W'(FIRST_CLUSTER);
    end_rel   = SECTOR_W'(res.run_start) + SECTOR_W'(res.run_length)
                - SECTOR_W'(FIRST_CLUSTER);
    first_sector = '0;
    last_sector  = '0;
    if (res.found) begin
      first_sector = start_rel * cs_ext + cfg.data_start_sector;
      last_sector  = end_rel * cs_ext + cfg.data_start_sector - SECTOR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= {last_sector, first_sector, res.run_length, res.run_start};
      out_user <= {res.size_met, res.found};
    end
  end

endmodule

// ----- design/fat32_free_run_finder.sv -----
// FAT32 free cluster run finder, top level: ports, configuration and input register.
// Depends on ffrf_pkg, ffrf_scan and ffrf_sector.
//
// Usage: FAT32 table entries stream in on s_axis, one per request, the first
// being cluster 2; s_axis_tlast marks the entry of the highest cluster. The
// block reports one result on m_axis when the open run reaches request_bytes
// (early stop) or on the last entry. After an early stop, entries are taken
// and dropped until the last one, which clears the scan state.
// Configuration writes arrive on cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. Write only while no result is pending.
// A result passes from the input register, which takes the request, to the scan
// register and then to the sector register before it shows on m_axis.
// Throughput: one entry per cycle while s_axis_tready is high; the scan state
// loop (increment, 8-bit by cluster-width product, compare) is combinational.
// Reset (rst, synchronous) empties the pipeline, restarts the scan at
// cluster 2 and loads the register defaults (0, 8, 0).
// When m_axis stalls, the output register holds; the scan keeps taking
// entries until a second result has nowhere to go, then s_axis_tready drops.
module fat32_free_run_finder
  import ffrf_pkg::*;
#(
  parameter int CLUSTER_BITS = CLUSTER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ENTRY_W-1:0]     s_axis_tdata,   // [31:0] fat_entry
  input  logic                   s_axis_tlast,   // last_entry
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [27:0] run_start, [55:28] run_length, [87:56] first_sector, [119:88] last_sector
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [OUT_USER_W-1:0]  m_axis_tuser,   // [0] found, [1] size_met
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t               cfg;
  logic               in_valid;
  logic [ENTRY_W-1:0] in_entry;
  logic               in_last;
  logic               scan_ready;
  logic               res_valid;
  logic               res_ready;
  run_result_t        res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !in_valid || scan_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_bytes     <= REQUEST_BYTES_RST;
      cfg.cluster_sectors   <= CLUSTER_SECTORS_RST;
      cfg.data_start_sector <= DATA_START_SECTOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REQUEST_BYTES:     cfg.request_bytes     <= cfg_data;
        REG_CLUSTER_SECTORS:   cfg.cluster_sectors   <= cfg_data[7:0];
        REG_DATA_START_SECTOR: cfg.data_start_sector <= cfg_data;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_entry <= s_axis_tdata;
      in_last  <= s_axis_tlast;
    end
  end

  ffrf_scan #(
    .CLUSTER_BITS(CLUSTER_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_entry (in_entry),
    .in_last  (in_last),
    .in_ready (scan_ready),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready)
  );

  ffrf_sector u_sector (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser)
  );

endmodule

// ----- design/ffrf_checker.sv -----
// Port-level checks on the run finder's result channel, bound to the top level.
// Depends on ffrf_pkg and fat32_free_run_finder.
module ffrf_checker
  import ffrf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no room: every data field reads zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("empty result carries data");

  // a found run has a nonzero start and length
  a_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[55:28] != '0
      && m_axis_tdata[27:0] != '0)
    else $error("found run with zero start or length");

  // an early stop comes only from a run of two or more clusters
  a_met: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]
      && m_axis_tdata[55:28] != 28'd1)
    else $error("size met on a single cluster run");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind fat32_free_run_finder ffrf_checker u_ffrf_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
